FILE: rtl/aprs_pkg.sv
// Shared types and constants of the analog pot round sampler.
package aprs_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_CONTROL  = 1'b0,
      CSR_TIMEOUT_TICKS = 1'b1
   } csr_index_type;

   // Widths of the fields.
   localparam int unsigned COUNTER_W = 16;
   localparam int unsigned AXIS_W    = 8;
   localparam int unsigned ACC_W     = 12;
   localparam int unsigned CTL_W     = 16;
   localparam int unsigned TICK_W    = 4;

   // Line control encodings and reset values.
   localparam logic [CTL_W-1:0]  LINE_DISABLED   = 16'hff00;
   localparam logic [CTL_W-1:0]  PORT_MODE_MASK  = 16'h0f00;
   localparam logic [CTL_W-1:0]  LINE_RESET      = LINE_DISABLED;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET   = 4'd4;

   // One input word: the packed counters of both ports.
   typedef struct packed {
      logic [COUNTER_W-1:0] port0_counter;
      logic [COUNTER_W-1:0] port1_counter;
   } req_word_type;

   // One result word: the coordinates of a finished round.
   typedef struct packed {
      logic [ACC_W-1:0] port0_x;
      logic [ACC_W-1:0] port0_y;
      logic [ACC_W-1:0] port1_x;
      logic [ACC_W-1:0] port1_y;
      logic [CTL_W-1:0] restart_word;
   } rsp_word_type;

   // What one port lane reports to the merge stage.
   typedef struct packed {
      logic             moved;
      logic [ACC_W-1:0] acc_x;
      logic [ACC_W-1:0] acc_y;
   } lane_status_type;

endpackage

FILE: rtl/analog_pot_round_sampler.sv
// Top level of the analog pot round sampler: config registers, two lanes and merge.
//
// Usage: each input word on the req_ channel is one periodic tick carrying the
// packed pot counters of both ports (x low byte, y high byte). A word is taken
// at a rising edge with req_valid high and req_stall low. Each port lane adds
// its axis deltas when its counter moved; the merge stage decides when a round
// ends and then places one result word on the rsp_ channel, taken at an edge
// with rsp_valid high and rsp_stall low.
// Timing: a round's result word is registered into the queue head, or into
// the skid entry while the head is stalled; rsp_valid comes from the head.
// Throughput: one tick per cycle while req_stall is low; a two-word result
// queue lets ticks keep flowing while a result waits. req_stall rises only
// when both queue entries are full, i.e. while the receiver holds off two results.
// Configuration: csr_write_en with csr_index 0 writes line_control, index 1
// writes timeout_ticks (csr_data[3:0]); write only while the block is idle.
// While line_control is 0xff00 ticks are taken and dropped with no effect.
// Reset (synchronous, active high) clears accumulators, remembered counters,
// tick count and the result queue, and loads line_control 0xff00, timeout 4.
module analog_pot_round_sampler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  aprs_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output aprs_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_write_en,
   input  logic [aprs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [aprs_pkg::CTL_W-1:0]          csr_data
);

   logic [aprs_pkg::CTL_W-1:0]  line_control_ff, line_control_in;
   logic [aprs_pkg::TICK_W-1:0] timeout_ff, timeout_in;
   logic                        step;
   logic                        skip0, skip1;
   logic                        round_end;
   aprs_pkg::lane_status_type   lane0, lane1;

   // Configuration register writes.
   always_comb begin
      line_control_in = line_control_ff;
      timeout_in      = timeout_ff;
      if (csr_write_en) begin
         unique case (aprs_pkg::csr_index_type'(csr_index))
            aprs_pkg::CSR_LINE_CONTROL:  line_control_in = csr_data;
            aprs_pkg::CSR_TIMEOUT_TICKS: timeout_in = csr_data[aprs_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_control_ff <= aprs_pkg::LINE_RESET;
         timeout_ff      <= aprs_pkg::TIMEOUT_RESET;
      end else begin
         line_control_ff <= line_control_in;
         timeout_ff      <= timeout_in;
      end
   end

   // A word does work only when the block is enabled.
   always_comb begin
      step  = req_valid && !req_stall && (line_control_ff != aprs_pkg::LINE_DISABLED);
      skip0 = (line_control_ff & aprs_pkg::PORT_MODE_MASK) != '0;
      skip1 = (line_control_ff & (aprs_pkg::PORT_MODE_MASK << 4)) != '0;
   end

   aprs_lane u_lane0 (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .skip    (skip0),
      .clear   (round_end),
      .counter (req_word.port0_counter),
      .status  (lane0)
   );

   aprs_lane u_lane1 (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .skip    (skip1),
      .clear   (round_end),
      .counter (req_word.port1_counter),
      .status  (lane1)
   );

   aprs_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .lane0         (lane0),
      .lane1         (lane1),
      .line_control  (line_control_ff),
      .timeout_ticks (timeout_ff),
      .round_end     (round_end),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word)
   );

endmodule

FILE: rtl/aprs_lane.sv
// One port lane: remembered counter, axis deltas and accumulators.
module aprs_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             skip,
   input  logic                             clear,
   input  logic [aprs_pkg::COUNTER_W-1:0]   counter,
   output aprs_pkg::lane_status_type        status
);

   logic [aprs_pkg::COUNTER_W-1:0] prev_ff, prev_in;
   logic [aprs_pkg::ACC_W-1:0]     acc_x_ff, acc_x_in;
   logic [aprs_pkg::ACC_W-1:0]     acc_y_ff, acc_y_in;
   logic [aprs_pkg::AXIS_W-1:0]    dx, dy;
   logic                           moved;
   logic [aprs_pkg::ACC_W-1:0]     sum_x, sum_y;

   // Wrapping 8-bit deltas of each axis and the updated sums.
   always_comb begin
      moved = (counter != prev_ff) && !skip;
      dx    = counter[aprs_pkg::AXIS_W-1:0] - prev_ff[aprs_pkg::AXIS_W-1:0];
      dy    = counter[aprs_pkg::COUNTER_W-1:aprs_pkg::AXIS_W]
            - prev_ff[aprs_pkg::COUNTER_W-1:aprs_pkg::AXIS_W];
      sum_x = moved ? acc_x_ff + {{(aprs_pkg::ACC_W-aprs_pkg::AXIS_W){1'b0}}, dx} : acc_x_ff;
      sum_y = moved ? acc_y_ff + {{(aprs_pkg::ACC_W-aprs_pkg::AXIS_W){1'b0}}, dy} : acc_y_ff;
   end

   assign status.moved = moved;
   assign status.acc_x = sum_x;
   assign status.acc_y = sum_y;

   // State update: a finished round clears the lane.
   always_comb begin
      prev_in  = prev_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      if (step) begin
         if (clear) begin
            prev_in  = '0;
            acc_x_in = '0;
            acc_y_in = '0;
         end else begin
            prev_in  = moved ? counter : prev_ff;
            acc_x_in = sum_x;
            acc_y_in = sum_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
      end
   end

endmodule

FILE: rtl/aprs_merge.sv
// Merge stage: tick counting, round end decision and the two-word result queue.
module aprs_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  aprs_pkg::lane_status_type       lane0,
   input  aprs_pkg::lane_status_type       lane1,
   input  logic [aprs_pkg::CTL_W-1:0]      line_control,
   input  logic [aprs_pkg::TICK_W-1:0]     timeout_ticks,
   output logic                            round_end,
   output logic                            req_stall,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output aprs_pkg::rsp_word_type          rsp_word
);

   logic [aprs_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [aprs_pkg::TICK_W-1:0] tick_next;
   logic                        any_moved;
   aprs_pkg::rsp_word_type      new_word;
   aprs_pkg::rsp_word_type      head_ff, head_in, skid_ff, skid_in;
   logic                        head_valid_ff, head_valid_in;
   logic                        skid_valid_ff, skid_valid_in;
   logic                        push, pop;

   // The round ends when no lane moved or the tick count reaches the timeout.
   always_comb begin
      any_moved = lane0.moved || lane1.moved;
      tick_next = tick_ff + 1'b1;
      round_end = !any_moved || (tick_next >= timeout_ticks);
      tick_in   = tick_ff;
      if (step) begin
         tick_in = round_end ? '0 : tick_next;
      end
   end

   // Result word built from the lanes' updated sums.
   always_comb begin
      new_word.port0_x      = lane0.acc_x;
      new_word.port0_y      = lane0.acc_y;
      new_word.port1_x      = lane1.acc_x;
      new_word.port1_y      = lane1.acc_y;
      new_word.restart_word = line_control | {{(aprs_pkg::CTL_W-1){1'b0}}, 1'b1};
   end

   // Two-entry queue: the head drives the result port, the skid entry takes
   // a word that arrives while the head is stalled.
   always_comb begin
      push          = step && round_end;
      pop           = head_valid_ff && !rsp_stall;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop || !head_valid_ff) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = new_word;
            skid_valid_in = push;
         end else begin
            head_in       = new_word;
            head_valid_in = push;
         end
      end else if (push) begin
         skid_in       = new_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         tick_ff       <= tick_in;
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign req_stall = skid_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_word  = head_ff;

endmodule

FILE: tb/sv/analog_pot_round_sampler_test.sv
// Self-checking testbench of the analog pot round sampler.
`timescale 1ns / 100ps

module analog_pot_round_sampler_test;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned SETTLE_LIMIT = 20000;
   localparam int unsigned PHASE_COUNT  = 12;
   localparam int unsigned PHASE_WORDS  = 135;
   localparam int unsigned PRESSURE_LEN = 150;

   // Clock, reset and the block's ports.
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   aprs_pkg::req_word_type        req_word = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   aprs_pkg::rsp_word_type        rsp_word;
   logic                          csr_write_en = 1'b0;
   aprs_pkg::csr_index_type       csr_index = aprs_pkg::CSR_LINE_CONTROL;
   logic [aprs_pkg::CTL_W-1:0]    csr_data = '0;

   // Words waiting to be driven and rounds waiting to be read back.
   aprs_pkg::req_word_type        pending_ticks[$];
   aprs_pkg::rsp_word_type        finished_rounds[$];
   int unsigned                   ticks_queued = 0;
   int unsigned                   ticks_taken = 0;
   logic                          req_fire = 1'b0;
   int unsigned                   mismatches = 0;
   int unsigned                   cycle_count = 0;

   // Idle rates and the long receiver hold-off.
   int unsigned                   send_idle_pct = 23;
   int unsigned                   recv_idle_pct = 56;
   logic                          pressure_armed = 1'b0;
   logic                          pressure_done = 1'b0;
   int unsigned                   hold_left = 0;

   // Mirror of the block's registers and round state.
   logic [aprs_pkg::CTL_W-1:0]     line_ctl_mirror = aprs_pkg::LINE_RESET;
   logic [aprs_pkg::TICK_W-1:0]    timeout_mirror = aprs_pkg::TIMEOUT_RESET;
   logic [aprs_pkg::TICK_W-1:0]    round_ticks = '0;
   logic [aprs_pkg::ACC_W-1:0]     axis_sum[4] = '{default: '0};
   logic [aprs_pkg::COUNTER_W-1:0] last_counter[2] = '{default: '0};

   analog_pot_round_sampler uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Adds one tick to the round and queues the coordinates when the round ends.
   function automatic void accumulate_tick(input aprs_pkg::req_word_type w);
      logic [aprs_pkg::COUNTER_W-1:0] cur[2];
      logic [aprs_pkg::CTL_W-1:0]     mode_mask;
      logic [aprs_pkg::AXIS_W-1:0]    dx;
      logic [aprs_pkg::AXIS_W-1:0]    dy;
      int unsigned                    idle_ports;
      aprs_pkg::rsp_word_type         r;
      if (line_ctl_mirror == aprs_pkg::LINE_DISABLED) begin
         return;
      end
      cur[0] = w.port0_counter;
      cur[1] = w.port1_counter;
      idle_ports = 0;
      for (int p = 0; p < 2; p++) begin
         mode_mask = aprs_pkg::PORT_MODE_MASK << (p * 4);
         if (cur[p] == last_counter[p] || (line_ctl_mirror & mode_mask) != '0) begin
            idle_ports++;
         end else begin
            // Each axis moves by its byte difference, modulo 256.
            dx = cur[p][7:0] - last_counter[p][7:0];
            dy = cur[p][15:8] - last_counter[p][15:8];
            axis_sum[2 * p] = axis_sum[2 * p]
               + {{(aprs_pkg::ACC_W-aprs_pkg::AXIS_W){1'b0}}, dx};
            axis_sum[2 * p + 1] = axis_sum[2 * p + 1]
               + {{(aprs_pkg::ACC_W-aprs_pkg::AXIS_W){1'b0}}, dy};
            last_counter[p] = cur[p];
         end
      end
      // A round with movement goes on until the tick count reaches the timeout.
      if (idle_ports != 2) begin
         round_ticks = round_ticks + 1'b1;
         if (round_ticks < timeout_mirror) begin
            return;
         end
      end
      r.port0_x = axis_sum[0];
      r.port0_y = axis_sum[1];
      r.port1_x = axis_sum[2];
      r.port1_y = axis_sum[3];
      r.restart_word = line_ctl_mirror | 16'h0001;
      finished_rounds.push_back(r);
      axis_sum = '{default: '0};
      last_counter = '{default: '0};
      round_ticks = '0;
   endfunction

   // Next counter value of one port: mostly small forward steps, some repeats.
   function automatic logic [aprs_pkg::COUNTER_W-1:0] next_counter(
      input logic [aprs_pkg::COUNTER_W-1:0] prev);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         return prev;
      end else if (pick < 80) begin
         return {prev[15:8] + 8'($urandom_range(40)), prev[7:0] + 8'($urandom_range(40))};
      end
      return 16'($urandom);
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic push_tick(input logic [aprs_pkg::COUNTER_W-1:0] p0,
                            input logic [aprs_pkg::COUNTER_W-1:0] p1);
      aprs_pkg::req_word_type w;
      w.port0_counter = p0;
      w.port1_counter = p1;
      pending_ticks.push_back(w);
      ticks_queued++;
   endtask

   task automatic csr_write(input aprs_pkg::csr_index_type idx,
                            input logic [aprs_pkg::CTL_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Waits until every word is taken and every round read back, or until SETTLE_LIMIT runs out.
   task automatic settle();
      int unsigned waited;
      waited = 0;
      while ((ticks_taken != ticks_queued || finished_rounds.size() != 0)
             && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   // Driver: a word stays on the channel until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_word <= pending_ticks.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, with one long hold-off when armed.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (pressure_armed && !pressure_done) begin
         rsp_stall <= 1'b1;
         hold_left <= PRESSURE_LEN;
         pressure_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: tracks register writes, checks results, predicts from taken ticks.
   always @(posedge clock) begin : monitor
      aprs_pkg::rsp_word_type want;
      if (reset) begin
         req_fire <= 1'b0;
         line_ctl_mirror = aprs_pkg::LINE_RESET;
         timeout_mirror = aprs_pkg::TIMEOUT_RESET;
         round_ticks = '0;
         axis_sum = '{default: '0};
         last_counter = '{default: '0};
      end else begin
         req_fire <= req_valid && !req_stall;
         if (csr_write_en) begin
            case (csr_index)
               aprs_pkg::CSR_LINE_CONTROL: begin
                  line_ctl_mirror = csr_data;
               end
               aprs_pkg::CSR_TIMEOUT_TICKS: begin
                  timeout_mirror = csr_data[aprs_pkg::TICK_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (finished_rounds.size() == 0) begin
               $error("result word 0x%0h with no round pending", rsp_word);
               mismatches++;
            end else begin
               want = finished_rounds.pop_front();
               check_field("port0_x", 16'(want.port0_x), 16'(rsp_word.port0_x));
               check_field("port0_y", 16'(want.port0_y), 16'(rsp_word.port0_y));
               check_field("port1_x", 16'(want.port1_x), 16'(rsp_word.port1_x));
               check_field("port1_y", 16'(want.port1_y), 16'(rsp_word.port1_y));
               check_field("restart_word", want.restart_word, rsp_word.restart_word);
            end
         end
         if (req_valid && !req_stall) begin
            ticks_taken++;
            accumulate_tick(req_word);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Stimulus: directed ticks, then random phases under several settings.
   initial begin : stimulus
      logic [aprs_pkg::COUNTER_W-1:0] gen0;
      logic [aprs_pkg::COUNTER_W-1:0] gen1;
      logic [aprs_pkg::CTL_W-1:0]     ctl;
      logic [aprs_pkg::TICK_W-1:0]    limit;
      logic [7:0]                     step;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Disabled after reset: these ticks must leave no trace.
      push_tick(16'h1234, 16'h5678);
      push_tick(16'hffff, 16'h0001);
      settle();

      // Both ports analog, longest timeout; a round ended by two idle ports.
      csr_write(aprs_pkg::CSR_LINE_CONTROL, 16'h0000);
      csr_write(aprs_pkg::CSR_TIMEOUT_TICKS, 16'h000f);
      push_tick(16'hffff, 16'hffff);
      push_tick(16'h0000, 16'h0000);
      push_tick(16'h0000, 16'h0000);
      // Largest deltas on every tick up to the timeout fill the accumulators.
      for (int k = 1; k <= 15; k++) begin
         step = 8'(-k);
         push_tick({step, step}, {step, step});
      end
      settle();

      // Timeout of zero ends the round on every tick.
      csr_write(aprs_pkg::CSR_TIMEOUT_TICKS, 16'h0000);
      push_tick(16'h00ff, 16'hff00);
      push_tick(16'h8001, 16'h7ffe);
      settle();

      // Port 1 not analog.
      csr_write(aprs_pkg::CSR_LINE_CONTROL, 16'hf000);
      push_tick(16'h4321, 16'h1111);
      push_tick(16'h4321, 16'h2222);
      settle();

      gen0 = '0;
      gen1 = '0;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         // Idle pattern for this phase; the long hold-off falls in the no-idle part.
         if (ph < 4) begin
            send_idle_pct = 23;
            recv_idle_pct = 56;
         end else if (ph < 8) begin
            send_idle_pct = 56;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Settings of the phase, extremes first.
         if (ph == 0) begin
            ctl = 16'h0000;
            limit = 4'd1;
         end else if (ph == 1) begin
            ctl = 16'hffff;
            limit = 4'd15;
         end else begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4: ctl = {8'h00, 8'($urandom)};
               5: ctl = {4'h0, 4'($urandom_range(1, 15)), 8'($urandom)};
               6: ctl = {4'($urandom_range(1, 15)), 4'h0, 8'($urandom)};
               7: ctl = {4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)), 8'($urandom)};
               default: ctl = 16'($urandom);
            endcase
            limit = 4'($urandom_range(1, 15));
         end
         csr_write(aprs_pkg::CSR_LINE_CONTROL, ctl);
         csr_write(aprs_pkg::CSR_TIMEOUT_TICKS, {12'($urandom), limit});
         if (ph == 8) begin
            pressure_armed = 1'b1;
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(99) >= 8) begin
               gen0 = next_counter(gen0);
               gen1 = next_counter(gen1);
            end
            push_tick(gen0, gen1);
         end
         settle();
      end

      if (finished_rounds.size() != 0) begin
         $error("%0d rounds never read back", finished_rounds.size());
      end
      if (mismatches == 0 && finished_rounds.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
